FILE: rtl/jsfe_pkg.sv
// Package for the JSON string field extractor.
// Holds window sizing, the phase type and the result kind codes.
// No dependencies.
`default_nettype none

package jsfe_pkg;

	localparam int MAX_NAME  = 24;
	localparam int WIN_DEPTH = MAX_NAME + 2;
	localparam int LEN_W     = 5;

	typedef logic [7:0] byte_t;
	typedef logic [LEN_W-1:0] len_t;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_COLON  = 3'd1,
		PH_SPACE  = 3'd2,
		PH_VALUE  = 3'd3,
		PH_ESCAPE = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_BYTE = 2'd0;
	localparam kind_t KIND_DONE = 2'd1;
	localparam kind_t KIND_FAIL = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_NAME_LENGTH = 2'd0;
	localparam cfg_idx_t REG_NAME_LOW    = 2'd1;
	localparam cfg_idx_t REG_NAME_MID    = 2'd2;
	localparam cfg_idx_t REG_NAME_HIGH   = 2'd3;

	localparam byte_t CH_QUOTE  = 8'h22;
	localparam byte_t CH_COLON  = 8'h3A;
	localparam byte_t CH_BSLASH = 8'h5C;
	localparam byte_t CH_N      = 8'h6E;
	localparam byte_t CH_R      = 8'h72;
	localparam byte_t CH_T      = 8'h74;
	localparam byte_t CH_SPACE  = 8'h20;
	localparam byte_t CH_TAB    = 8'h09;
	localparam byte_t CH_LF     = 8'h0A;
	localparam byte_t CH_CR     = 8'h0D;

endpackage

`default_nettype wire

FILE: rtl/json_string_field_extractor_top.sv
// JSON string field extractor, top level.
// Usage: program the field name over the configuration port while idle,
// then stream a document in one byte per item on the input channel
// (first_byte opens a document, last_byte or a zero byte closes it).
// The value string comes out one unescaped byte per result item, followed
// by a completion item (kind 1) at the closing quote, or a single failure
// item (kind 2) when the field is not found or the value is malformed.
// Many bytes (search, colon, white space, escape) produce no result item.
// An accepted item is held in the input register and evaluated from it;
// its result is registered in the output register. Throughput: one byte
// per cycle while out_stall is low; the name compare over the 26-byte
// window and the phase update fit in the single evaluation stage.
// Stalls: when out_stall holds the output register full, the input
// register fills and in_stall rises; nothing is lost or repeated.
// Reset clears the phase to searching, the window to zeros and the name
// registers to length one with zero bytes. cfg_ready is always high.
// Depends on jsfe_pkg.
`default_nettype none

module json_string_field_extractor_top import jsfe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	// document bytes
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  doc_byte,
	input  wire logic        first_byte,
	input  wire logic        last_byte,
	// results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       value_byte,
	output logic [1:0]       kind
);

	// configuration registers
	len_t          name_len_q;
	logic [63:0]   name_low_q, name_mid_q, name_high_q;

	// input stage
	logic          valid_s1;
	byte_t         byte_s1;
	logic          first_s1, last_s1;

	// document state
	byte_t         win_q [WIN_DEPTH];
	phase_t        phase_q;

	// output register
	logic          out_valid_q;
	byte_t         value_q;
	kind_t         kind_q;

	logic          out_free, advance, in_accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_len_q  <= len_t'(1);
			name_low_q  <= '0;
			name_mid_q  <= '0;
			name_high_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NAME_LENGTH: name_len_q  <= cfg_data[LEN_W-1:0];
				REG_NAME_LOW:    name_low_q  <= cfg_data;
				REG_NAME_MID:    name_mid_q  <= cfg_data;
				REG_NAME_HIGH:   name_high_q <= cfg_data;
				default:         name_len_q  <= name_len_q;
			endcase
		end
	end

	// handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1  <= doc_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	// name bytes lined up against window positions for the current length
	byte_t  name_arr [MAX_NAME];
	byte_t  pat      [MAX_NAME+1];
	len_t   len_c;
	len_t   pat_k;

	always_comb begin
		len_c = (name_len_q > len_t'(MAX_NAME)) ? len_t'(MAX_NAME) : name_len_q;
		for (int i = 0; i < 8; i++) begin
			name_arr[i]    = name_low_q[i*8 +: 8];
			name_arr[i+8]  = name_mid_q[i*8 +: 8];
			name_arr[i+16] = name_high_q[i*8 +: 8];
		end
		pat[0] = CH_QUOTE;
		pat_k  = '0;
		for (int j = 1; j <= MAX_NAME; j++) begin
			pat_k  = len_c - len_t'(j);
			pat[j] = name_arr[pat_k];
		end
	end

	// evaluation of the byte held in the input stage
	byte_t  win_cur  [WIN_DEPTH];
	byte_t  win_sh   [WIN_DEPTH];
	byte_t  win_next [WIN_DEPTH];
	phase_t ph_cur, ph_next;
	logic   match, have, is_space;
	kind_t  kind_c;
	byte_t  val_c;
	len_t   q_pos;

	always_comb begin
		ph_cur = first_s1 ? PH_SEARCH : phase_q;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			win_cur[i] = first_s1 ? byte_t'(0) : win_q[i];
		end
		win_sh[0] = byte_s1;
		for (int i = 1; i < WIN_DEPTH; i++) begin
			win_sh[i] = win_cur[i-1];
		end

		q_pos = len_c + len_t'(1);
		match = (win_sh[0] == CH_QUOTE) && (win_sh[q_pos] == CH_QUOTE);
		for (int j = 1; j <= MAX_NAME; j++) begin
			if (len_t'(j) <= len_c && win_sh[j] != pat[j]) begin
				match = 1'b0;
			end
		end

		is_space = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB) ||
		           (byte_s1 == CH_LF) || (byte_s1 == CH_CR);

		win_next = win_cur;
		ph_next  = ph_cur;
		have     = 1'b0;
		kind_c   = KIND_FAIL;
		val_c    = '0;

		if (ph_cur != PH_DONE) begin
			if (byte_s1 == 8'h00) begin
				have    = 1'b1;
				ph_next = PH_DONE;
			end else begin
				case (ph_cur)
					PH_SEARCH: begin
						win_next = win_sh;
						if (match) ph_next = PH_COLON;
					end
					PH_COLON: begin
						if (byte_s1 == CH_COLON) ph_next = PH_SPACE;
					end
					PH_SPACE: begin
						if (byte_s1 == CH_QUOTE) begin
							ph_next = PH_VALUE;
						end else if (!is_space) begin
							have    = 1'b1;
							ph_next = PH_DONE;
						end
					end
					PH_VALUE: begin
						if (byte_s1 == CH_BSLASH) begin
							ph_next = PH_ESCAPE;
						end else if (byte_s1 == CH_QUOTE) begin
							have    = 1'b1;
							kind_c  = KIND_DONE;
							ph_next = PH_DONE;
						end else begin
							have   = 1'b1;
							kind_c = KIND_BYTE;
							val_c  = byte_s1;
						end
					end
					PH_ESCAPE: begin
						have    = 1'b1;
						kind_c  = KIND_BYTE;
						ph_next = PH_VALUE;
						case (byte_s1)
							CH_N:    val_c = CH_LF;
							CH_R:    val_c = CH_CR;
							CH_T:    val_c = CH_TAB;
							default: val_c = byte_s1;
						endcase
					end
					default: ph_next = ph_cur;
				endcase
			end
			// a last byte that did not finish the value fails the field
			if (last_s1 && ph_next != PH_DONE) begin
				have    = 1'b1;
				kind_c  = KIND_FAIL;
				val_c   = '0;
				ph_next = PH_DONE;
			end
			if (kind_c != KIND_BYTE) val_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
		end else if (advance) begin
			phase_q <= ph_next;
			win_q   <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && have;
		end
	end

	// hold the payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (out_free) begin
			value_q <= val_c;
			kind_q  <= kind_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign value_byte = value_q;
	assign kind       = kind_q;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for json_string_field_extractor_top: directed documents, then random documents
// under changing field names, checked against an in-bench extraction predictor.
// Depends on jsfe_pkg and the RTL top level.
module tb_top import jsfe_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int    IDLE_LIMIT   = 4000;
	localparam int    RANDOM_ITEMS = 1750;
	localparam int    SETTLE       = 4;
	localparam byte_t NUL_BYTE     = 8'h00;

	typedef struct packed {
		byte_t value;
		kind_t kind;
	} value_item_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
	typedef enum {NAME_TEXT, NAME_COLON, NAME_ZERO, NAME_RAW} name_style_t;
	typedef enum {
		DOC_GOOD, DOC_NO_QUOTE, DOC_TRUNCATED, DOC_ZERO, DOC_NO_FIRST, DOC_NO_COLON, DOC_NOISE
	} doc_shape_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index  = '0;
	logic [63:0] cfg_data   = '0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [7:0]  doc_byte   = '0;
	logic        first_byte = 1'b0;
	logic        last_byte  = 1'b0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [7:0]  value_byte;
	logic [1:0]  kind;

	// predictor state
	byte_t        win_bytes [WIN_DEPTH];
	phase_t       doc_phase;
	len_t         name_len;
	logic [191:0] name_bits;
	value_item_t  pending_q [$];

	byte_t        doc_q [$];
	stall_mode_t  stall_mode   = STALL_NONE;
	bit           sender_gaps  = 1'b0;
	int           burst_left   = 0;
	int           items_sent   = 0;
	int           err_count    = 0;
	int           idle_cycles  = 0;
	int unsigned  stall_tick   = 0;

	json_string_field_extractor_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.doc_byte   (doc_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value_byte (value_byte),
		.kind       (kind)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
			STALL_PERIODIC: out_stall <= ((stall_tick % 11) < 4);
			default:        out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		value_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result: value %02h kind %0d", $time, value_byte, kind);
				err_count++;
			end else begin
				want = pending_q.pop_front();
				if (value_byte !== want.value || kind !== want.kind) begin
					$display("%0t: result mismatch: expected value %02h kind %0d, got value %02h kind %0d",
						$time, want.value, want.kind, value_byte, kind);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("FAIL json_string_field_extractor_top");
			$finish;
		end
	end

	// Work out the result, if any, of one accepted document byte.
	function automatic void extract_step(byte_t b, logic f, logic l);
		int          i;
		int          eff;
		bit          have;
		bit          hit;
		value_item_t r;
		have = 1'b0;
		r.kind = KIND_FAIL;
		r.value = NUL_BYTE;
		if (f) begin
			for (i = 0; i < WIN_DEPTH; i++)
				win_bytes[i] = NUL_BYTE;
			doc_phase = PH_SEARCH;
		end
		if (doc_phase == PH_DONE)
			return;
		if (b == NUL_BYTE) begin
			have = 1'b1;
			r.kind = KIND_FAIL;
			doc_phase = PH_DONE;
		end else begin
			case (doc_phase)
				PH_SEARCH: begin
					for (i = WIN_DEPTH - 1; i > 0; i--)
						win_bytes[i] = win_bytes[i-1];
					win_bytes[0] = b;
					eff = (int'(name_len) > MAX_NAME) ? MAX_NAME : int'(name_len);
					hit = (win_bytes[0] == CH_QUOTE) && (win_bytes[eff+1] == CH_QUOTE);
					for (i = 0; i < eff; i++)
						if (win_bytes[eff-i] != name_bits[i*8 +: 8])
							hit = 1'b0;
					if (hit)
						doc_phase = PH_COLON;
				end
				PH_COLON: begin
					if (b == CH_COLON)
						doc_phase = PH_SPACE;
				end
				PH_SPACE: begin
					if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
						// stay
					end else if (b == CH_QUOTE) begin
						doc_phase = PH_VALUE;
					end else begin
						have = 1'b1;
						r.kind = KIND_FAIL;
						doc_phase = PH_DONE;
					end
				end
				PH_VALUE: begin
					if (b == CH_BSLASH) begin
						doc_phase = PH_ESCAPE;
					end else if (b == CH_QUOTE) begin
						have = 1'b1;
						r.kind = KIND_DONE;
						doc_phase = PH_DONE;
					end else begin
						have = 1'b1;
						r.kind = KIND_BYTE;
						r.value = b;
					end
				end
				default: begin
					have = 1'b1;
					r.kind = KIND_BYTE;
					if (b == CH_N)
						r.value = CH_LF;
					else if (b == CH_R)
						r.value = CH_CR;
					else if (b == CH_T)
						r.value = CH_TAB;
					else
						r.value = b;
					doc_phase = PH_VALUE;
				end
			endcase
		end
		if (l && doc_phase != PH_DONE) begin
			have = 1'b1;
			r.kind = KIND_FAIL;
			doc_phase = PH_DONE;
		end
		if (have) begin
			if (r.kind != KIND_BYTE)
				r.value = NUL_BYTE;
			pending_q.push_back(r);
		end
	endfunction

	task automatic send_item(byte_t b, logic f, logic l);
		int gap;
		if (sender_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		doc_byte <= b;
		first_byte <= f;
		last_byte <= l;
		do
			@(posedge clk);
		while (in_stall);
		extract_step(b, f, l);
		items_sent++;
	endtask

	task automatic send_queue(bit with_first, bit with_last);
		int i;
		for (i = 0; i < doc_q.size(); i++)
			send_item(doc_q[i], with_first && (i == 0), with_last && (i == doc_q.size() - 1));
	endtask

	// Drop valid, drain every pending result, then let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_name(logic [63:0] len_word, logic [191:0] bytes);
		int          i;
		logic [63:0] words [4];
		words[0] = len_word;
		words[1] = bytes[63:0];
		words[2] = bytes[127:64];
		words[3] = bytes[191:128];
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= words[i];
			do
				@(posedge clk);
			while (!cfg_ready);
			case (cfg_idx_t'(i))
				REG_NAME_LENGTH: name_len = words[i][LEN_W-1:0];
				REG_NAME_LOW:    name_bits[63:0] = words[i];
				REG_NAME_MID:    name_bits[127:64] = words[i];
				REG_NAME_HIGH:   name_bits[191:128] = words[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_doc(doc_shape_t shape);
		int    i;
		int    eff;
		int    n;
		int    cut;
		bit    with_first;
		bit    with_last;
		byte_t c;
		doc_q.delete();
		with_first = (shape != DOC_NO_FIRST);
		with_last = 1'b1;
		if (shape == DOC_NOISE) begin
			n = $urandom_range(1, 40);
			for (i = 0; i < n; i++)
				doc_q.push_back(byte_t'($urandom_range(0, 255)));
		end else begin
			eff = (int'(name_len) > MAX_NAME) ? MAX_NAME : int'(name_len);
			n = $urandom_range(0, 6);
			for (i = 0; i < n; i++)
				doc_q.push_back(byte_t'($urandom_range(1, 255)));
			doc_q.push_back(CH_QUOTE);
			for (i = 0; i < eff; i++)
				doc_q.push_back(name_bits[i*8 +: 8]);
			doc_q.push_back(CH_QUOTE);
			n = $urandom_range(0, 3);
			for (i = 0; i < n; i++) begin
				c = byte_t'($urandom_range(1, 255));
				doc_q.push_back((c == CH_COLON) ? CH_SPACE : c);
			end
			if (shape != DOC_NO_COLON) begin
				doc_q.push_back(CH_COLON);
				n = $urandom_range(0, 3);
				for (i = 0; i < n; i++)
					case ($urandom_range(0, 3))
						0:       doc_q.push_back(CH_SPACE);
						1:       doc_q.push_back(CH_TAB);
						2:       doc_q.push_back(CH_LF);
						default: doc_q.push_back(CH_CR);
					endcase
				if (shape == DOC_NO_QUOTE) begin
					c = byte_t'($urandom_range(8'h21, 8'hFF));
					doc_q.push_back((c == CH_QUOTE) ? CH_BSLASH : c);
				end else begin
					doc_q.push_back(CH_QUOTE);
				end
				n = $urandom_range(0, 12);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(0, 9) < 2) begin
						doc_q.push_back(CH_BSLASH);
						case ($urandom_range(0, 5))
							0:       doc_q.push_back(CH_N);
							1:       doc_q.push_back(CH_R);
							2:       doc_q.push_back(CH_T);
							3:       doc_q.push_back(CH_QUOTE);
							4:       doc_q.push_back(CH_BSLASH);
							default: doc_q.push_back(byte_t'($urandom_range(0, 255)));
						endcase
					end else begin
						c = byte_t'($urandom_range(1, 255));
						doc_q.push_back((c == CH_QUOTE || c == CH_BSLASH) ? 8'h41 : c);
					end
				end
				if (shape == DOC_ZERO)
					doc_q.insert($urandom_range(0, doc_q.size()), NUL_BYTE);
				doc_q.push_back(CH_QUOTE);
				n = $urandom_range(0, 4);
				for (i = 0; i < n; i++)
					doc_q.push_back(byte_t'($urandom_range(0, 255)));
			end
		end
		if (shape == DOC_TRUNCATED) begin
			cut = $urandom_range(1, doc_q.size());
			doc_q = doc_q[0:cut-1];
			with_last = ($urandom_range(0, 3) != 0);
		end
		send_queue(with_first, with_last);
	endtask

	// Bytes straight after reset form a document even without a first marker.
	task automatic test_reset_document();
		doc_q = '{8'h78, 8'h80};
		send_queue(1'b0, 1'b1);
		wait_idle();
	endtask

	task automatic test_escapes();
		write_name(64'd1, {128'd0, 56'd0, 8'h6B});
		// last marker lands after completion and is ignored
		doc_q = '{CH_QUOTE, 8'h6B, CH_QUOTE, CH_COLON, CH_SPACE, CH_TAB, CH_QUOTE,
			CH_BSLASH, CH_N, CH_BSLASH, CH_R, CH_BSLASH, CH_T, CH_BSLASH, CH_QUOTE,
			8'hFF, CH_QUOTE, 8'h7A};
		send_queue(1'b1, 1'b1);
		wait_idle();
	endtask

	task automatic test_malformed();
		doc_q = '{NUL_BYTE};
		send_queue(1'b1, 1'b1);
		doc_q = '{CH_QUOTE, 8'h6B, CH_QUOTE, CH_COLON, 8'h78};
		send_queue(1'b1, 1'b0);
		// last marker on a value byte replaces it with a failure
		doc_q = '{CH_QUOTE, 8'h6B, CH_QUOTE, CH_COLON, CH_QUOTE, 8'h61};
		send_queue(1'b1, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_documents();
		int           start;
		int           round;
		int           len;
		int           eff;
		int           k;
		int           d;
		int           r;
		name_style_t  style;
		logic [191:0] bytes;
		logic [63:0]  len_word;
		doc_shape_t   shape;
		start = items_sent;
		round = 0;
		while (items_sent - start < RANDOM_ITEMS) begin
			case (round % 6)
				0:       len = 0;
				1:       len = 1;
				2:       len = MAX_NAME;
				3:       len = $urandom_range(MAX_NAME + 1, 31);
				default: len = $urandom_range(1, MAX_NAME);
			endcase
			eff = (len > MAX_NAME) ? MAX_NAME : len;
			style = name_style_t'($urandom_range(0, 3));
			bytes = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			if (style != NAME_RAW)
				for (k = 0; k < eff; k++)
					bytes[k*8 +: 8] = byte_t'($urandom_range(8'h21, 8'h7E));
			if (eff > 0 && style == NAME_COLON)
				bytes[$urandom_range(0, eff - 1)*8 +: 8] = CH_COLON;
			if (eff > 0 && style == NAME_ZERO)
				bytes[$urandom_range(0, eff - 1)*8 +: 8] = NUL_BYTE;
			len_word = {$urandom, $urandom};
			len_word[LEN_W-1:0] = len_t'(len);
			write_name(len_word, bytes);
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			sender_gaps = $urandom_range(0, 2) != 0;
			for (d = 0; d < 8; d++) begin
				r = $urandom_range(0, 19);
				if (r < 11)
					shape = DOC_GOOD;
				else if (r == 11)
					shape = DOC_NO_QUOTE;
				else if (r < 14)
					shape = DOC_TRUNCATED;
				else if (r == 14)
					shape = DOC_ZERO;
				else if (r == 15)
					shape = DOC_NO_FIRST;
				else if (r == 16)
					shape = DOC_NO_COLON;
				else
					shape = DOC_NOISE;
				send_doc(shape);
			end
			wait_idle();
			round++;
		end
	endtask

	initial begin
		for (int i = 0; i < WIN_DEPTH; i++)
			win_bytes[i] = NUL_BYTE;
		doc_phase = PH_SEARCH;
		name_len = len_t'(1);
		name_bits = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_document();
		stall_mode = STALL_LIGHT;
		test_escapes();
		stall_mode = STALL_PERIODIC;
		sender_gaps = 1'b1;
		test_malformed();
		test_random_documents();
		stall_mode = STALL_NONE;
		wait_idle();
		if (err_count == 0 && pending_q.size() == 0)
			$display("PASS json_string_field_extractor_top");
		else
			$display("FAIL json_string_field_extractor_top");
		$finish;
	end

endmodule

FILE: files.f
rtl/jsfe_pkg.sv
rtl/json_string_field_extractor_top.sv
sim/tb_top.sv
